@@ design/dss_pkg.sv @@
// Package for the dual stack block: sizes, operation and status codes,
// item, result and internal command types. No dependencies.
package dss_pkg;

	localparam int DEPTH       = 16;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int ADDR_TOP    = DEPTH - 1;
	localparam int WORD_W      = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] OP_PUSH_X = 3'd0;
	localparam logic [2:0] OP_PUSH_Y = 3'd1;
	localparam logic [2:0] OP_POP_X  = 3'd2;
	localparam logic [2:0] OP_POP_Y  = 3'd3;
	localparam logic [2:0] OP_SHOW_X = 3'd4;
	localparam logic [2:0] OP_SHOW_Y = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_OVER  = 2'd1;
	localparam logic [1:0] ST_UNDER = 2'd2;

	// What the back end does with a queued command
	localparam logic [1:0] K_WRITE  = 2'd0;
	localparam logic [1:0] K_READ   = 2'd1;
	localparam logic [1:0] K_STATUS = 2'd2;

	typedef struct packed {
		logic [2:0]               op;
		logic signed [WORD_W-1:0] push_value;
	} item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] read_value;
		logic [1:0]               status;
		logic                     last;
	} result_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] data;
		logic [1:0]        status;
		logic              last;
	} cmd_t;

endpackage

@@ design/dss_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
module dss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

@@ design/dss_front.sv @@
// Front end: accepts items, keeps both stack counts, classifies each item
// and expands show operations into one command per word. Uses dss_pkg.
module dss_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  dss_pkg::item_t item,
	input  logic          q_full,
	output logic          busy,
	output logic          cmd_push,
	output dss_pkg::cmd_t  cmd
);

	logic [dss_pkg::CNT_W-1:0]  x_count_q, x_count_d;
	logic [dss_pkg::CNT_W-1:0]  y_count_q, y_count_d;
	logic                       show_q, show_d;
	logic                       down_q, down_d;
	logic [dss_pkg::CNT_W-1:0]  rem_q, rem_d;
	logic [dss_pkg::ADDR_W-1:0] cursor_q, cursor_d;
	logic [dss_pkg::CNT_W:0]    fill;
	logic                       full;
	logic                       accept;

	assign busy   = show_q || q_full;
	assign accept = start && !busy;
	assign fill   = {1'b0, x_count_q} + {1'b0, y_count_q};
	assign full   = fill >= (dss_pkg::CNT_W + 1)'(dss_pkg::DEPTH);

	always_comb begin
		x_count_d = x_count_q;
		y_count_d = y_count_q;
		show_d    = show_q;
		down_d    = down_q;
		rem_d     = rem_q;
		cursor_d  = cursor_q;
		cmd_push  = 1'b0;
		cmd       = '0;
		cmd.kind  = dss_pkg::K_STATUS;
		cmd.data  = item.push_value;
		cmd.last  = 1'b1;
		if (show_q) begin
			// advance through the stack, one word per transfer into the queue
			if (!q_full) begin
				cmd_push = 1'b1;
				cmd.kind = dss_pkg::K_READ;
				cmd.addr = cursor_q;
				cmd.last = rem_q == dss_pkg::CNT_W'(1);
				rem_d    = rem_q - dss_pkg::CNT_W'(1);
				cursor_d = down_q ? cursor_q - dss_pkg::ADDR_W'(1)
				                  : cursor_q + dss_pkg::ADDR_W'(1);
				if (rem_q == dss_pkg::CNT_W'(1)) begin
					show_d = 1'b0;
				end
			end
		end else if (accept) begin
			unique case (item.op)
				dss_pkg::OP_PUSH_X: begin
					cmd_push = 1'b1;
					if (full) begin
						cmd.status = dss_pkg::ST_OVER;
					end else begin
						cmd.kind  = dss_pkg::K_WRITE;
						cmd.addr  = dss_pkg::ADDR_W'(x_count_q);
						x_count_d = x_count_q + dss_pkg::CNT_W'(1);
					end
				end
				dss_pkg::OP_PUSH_Y: begin
					cmd_push = 1'b1;
					if (full) begin
						cmd.status = dss_pkg::ST_OVER;
					end else begin
						cmd.kind  = dss_pkg::K_WRITE;
						cmd.addr  = dss_pkg::ADDR_W'(dss_pkg::CNT_W'(dss_pkg::ADDR_TOP)
						                             - y_count_q);
						y_count_d = y_count_q + dss_pkg::CNT_W'(1);
					end
				end
				dss_pkg::OP_POP_X: begin
					cmd_push = 1'b1;
					if (x_count_q == '0) begin
						cmd.status = dss_pkg::ST_UNDER;
					end else begin
						cmd.kind  = dss_pkg::K_READ;
						cmd.addr  = dss_pkg::ADDR_W'(x_count_q - dss_pkg::CNT_W'(1));
						x_count_d = x_count_q - dss_pkg::CNT_W'(1);
					end
				end
				dss_pkg::OP_POP_Y: begin
					cmd_push = 1'b1;
					if (y_count_q == '0) begin
						cmd.status = dss_pkg::ST_UNDER;
					end else begin
						cmd.kind  = dss_pkg::K_READ;
						cmd.addr  = dss_pkg::ADDR_W'(dss_pkg::CNT_W'(dss_pkg::DEPTH)
						                             - y_count_q);
						y_count_d = y_count_q - dss_pkg::CNT_W'(1);
					end
				end
				dss_pkg::OP_SHOW_X: begin
					cmd_push = 1'b1;
					if (x_count_q == '0) begin
						cmd.status = dss_pkg::ST_UNDER;
					end else begin
						cmd.kind = dss_pkg::K_READ;
						cmd.addr = '0;
						cmd.last = x_count_q == dss_pkg::CNT_W'(1);
						show_d   = x_count_q != dss_pkg::CNT_W'(1);
						down_d   = 1'b0;
						rem_d    = x_count_q - dss_pkg::CNT_W'(1);
						cursor_d = dss_pkg::ADDR_W'(1);
					end
				end
				dss_pkg::OP_SHOW_Y: begin
					cmd_push = 1'b1;
					if (y_count_q == '0) begin
						cmd.status = dss_pkg::ST_UNDER;
					end else begin
						cmd.kind = dss_pkg::K_READ;
						cmd.addr = dss_pkg::ADDR_W'(dss_pkg::ADDR_TOP);
						cmd.last = y_count_q == dss_pkg::CNT_W'(1);
						show_d   = y_count_q != dss_pkg::CNT_W'(1);
						down_d   = 1'b1;
						rem_d    = y_count_q - dss_pkg::CNT_W'(1);
						cursor_d = dss_pkg::ADDR_W'(dss_pkg::ADDR_TOP - 1);
					end
				end
				default: begin
					// unused codes: drop the item
					cmd_push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_count_q <= '0;
			y_count_q <= '0;
			show_q    <= 1'b0;
			down_q    <= 1'b0;
			rem_q     <= '0;
			cursor_q  <= '0;
		end else begin
			x_count_q <= x_count_d;
			y_count_q <= y_count_d;
			show_q    <= show_d;
			down_q    <= down_d;
			rem_q     <= rem_d;
			cursor_q  <= cursor_d;
		end
	end

endmodule

@@ design/dss_queue.sv @@
// Short command queue between front end and back end.
// Uses dss_pkg for the command type and depth.
module dss_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dss_pkg::cmd_t  din,
	output logic          full,
	input  logic          pop,
	output dss_pkg::cmd_t  dout,
	output logic          empty
);

	dss_pkg::cmd_t               entry_q [dss_pkg::QUEUE_DEPTH];
	logic [dss_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [dss_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [dss_pkg::QCNT_W-1:0]  count_q;
	logic                        do_push;
	logic                        do_pop;

	assign full    = count_q == dss_pkg::QCNT_W'(dss_pkg::QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == dss_pkg::QPTR_W'(dss_pkg::QUEUE_DEPTH - 1))
				            ? '0 : wr_ptr_q + dss_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == dss_pkg::QPTR_W'(dss_pkg::QUEUE_DEPTH - 1))
				            ? '0 : rd_ptr_q + dss_pkg::QPTR_W'(1);
			end
			count_q <= count_q + dss_pkg::QCNT_W'(do_push) - dss_pkg::QCNT_W'(do_pop);
		end
	end

endmodule

@@ design/dss_back.sv @@
// Back end: drains one command per cycle, performs the memory access and
// drives the result strobe. Uses dss_pkg and dss_ram.
module dss_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  dss_pkg::cmd_t    q_head,
	output logic            q_pop,
	output logic            strobe,
	output dss_pkg::result_t result
);

	logic                       valid_s1;
	logic [1:0]                 kind_s1;
	logic [1:0]                 status_s1;
	logic                       last_s1;
	logic [dss_pkg::WORD_W-1:0] rdata;

	// the receiver never stalls, so take the head whenever there is one
	assign q_pop = !q_empty;

	dss_ram #(
		.WIDTH(dss_pkg::WORD_W),
		.DEPTH(dss_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (q_pop && q_head.kind == dss_pkg::K_WRITE),
		.addr (q_head.addr),
		.wdata(q_head.data),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1   <= q_head.kind;
		status_s1 <= q_head.status;
		last_s1   <= q_head.last;
	end

	assign strobe            = valid_s1;
	assign result.read_value = (kind_s1 == dss_pkg::K_READ) ? rdata : '0;
	assign result.status     = status_s1;
	assign result.last       = last_s1;

endmodule

@@ design/dual_stack_shared_memory.sv @@
// Two stacks in one RAM: X grows up from word 0, Y grows down from the top word.
// A result strobes after its command passes through the queue and the RAM read.
// Push and pop accept one item per cycle while busy is low; a show of N words
// emits one word per cycle and holds busy until its last word is queued.
// Reset clears both counts and the queue; RAM contents are kept. No result stall.
module dual_stack_shared_memory (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  dss_pkg::item_t   item,
	output logic            strobe,
	output dss_pkg::result_t result
);

	logic          cmd_push;
	dss_pkg::cmd_t cmd;
	logic          q_full;
	logic          q_empty;
	logic          q_pop;
	dss_pkg::cmd_t q_head;

	dss_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.item    (item),
		.q_full  (q_full),
		.busy    (busy),
		.cmd_push(cmd_push),
		.cmd     (cmd)
	);

	dss_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.din   (cmd),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_head),
		.empty (q_empty)
	);

	dss_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_head (q_head),
		.q_pop  (q_pop),
		.strobe (strobe),
		.result (result)
	);

`ifndef ASSERT_OFF
	a_no_queue_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_push && q_full))
		else $error("command dropped at full queue");

	a_strobe_follows_dequeue: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> strobe)
		else $error("dequeued command gave no result");

	a_error_has_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.status != dss_pkg::ST_OK) |-> (result.read_value == '0))
		else $error("error result carries a nonzero word");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.status != dss_pkg::ST_OK) |-> result.last)
		else $error("error result not marked last");
`endif

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for dual_stack_shared_memory: directed table, then random
// fill/drain/mixed phases, checked against a behavioral copy of the two stacks.
// Depends on dss_pkg and the dual_stack_shared_memory RTL.
module testbench;
	import dss_pkg::*;

	localparam logic [2:0] OP_UNUSED_6 = 3'd6;
	localparam logic [2:0] OP_UNUSED_7 = 3'd7;
	localparam int         RANDOM_OPS  = 325;
	localparam int         N_DIRECTED  = 22;

	typedef struct packed {
		item_t   it;
		logic    check;
		result_t want;
	} stim_row_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    strobe;
	result_t result;

	// Shadow of the two stacks and the results they still owe
	logic [WORD_W-1:0] stack_mem [DEPTH];
	int                x_cnt;
	int                y_cnt;
	result_t           results_due[$];
	result_t           want_res;
	int                fail_count = 0;
	int                idle_style;
	stim_row_t         dir_rows [N_DIRECTED];

	dual_stack_shared_memory u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t mk_res(logic [WORD_W-1:0] value, logic [1:0] st, logic lst);
		result_t r;
		r.read_value = value;
		r.status     = st;
		r.last       = lst;
		return r;
	endfunction

	// Work out the results one accepted command owes and update the shadow stacks
	function automatic void apply_stack_op(item_t it);
		int i;
		case (it.op)
			OP_PUSH_X, OP_PUSH_Y: begin
				if (x_cnt + y_cnt >= DEPTH) begin
					results_due.push_back(mk_res('0, ST_OVER, 1'b1));
				end else begin
					if (it.op == OP_PUSH_X) begin
						stack_mem[x_cnt] = it.push_value;
						x_cnt++;
					end else begin
						y_cnt++;
						stack_mem[DEPTH - y_cnt] = it.push_value;
					end
					results_due.push_back(mk_res('0, ST_OK, 1'b1));
				end
			end
			OP_POP_X: begin
				if (x_cnt == 0) begin
					results_due.push_back(mk_res('0, ST_UNDER, 1'b1));
				end else begin
					x_cnt--;
					results_due.push_back(mk_res(stack_mem[x_cnt], ST_OK, 1'b1));
				end
			end
			OP_POP_Y: begin
				if (y_cnt == 0) begin
					results_due.push_back(mk_res('0, ST_UNDER, 1'b1));
				end else begin
					results_due.push_back(mk_res(stack_mem[DEPTH - y_cnt], ST_OK, 1'b1));
					y_cnt--;
				end
			end
			OP_SHOW_X: begin
				if (x_cnt == 0)
					results_due.push_back(mk_res('0, ST_UNDER, 1'b1));
				for (i = 0; i < x_cnt; i++)
					results_due.push_back(mk_res(stack_mem[i], ST_OK, i == x_cnt - 1));
			end
			OP_SHOW_Y: begin
				if (y_cnt == 0)
					results_due.push_back(mk_res('0, ST_UNDER, 1'b1));
				for (i = 0; i < y_cnt; i++)
					results_due.push_back(mk_res(stack_mem[DEPTH - 1 - i], ST_OK,
						i == y_cnt - 1));
			end
			default: ;
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic int draw_gap();
		case (idle_style)
			0:       return 0;
			1:       return $urandom_range(0, 2);
			default: return $urandom_range(0, 18);
		endcase
	endfunction

	function automatic item_t mk_item(logic [2:0] op, logic [WORD_W-1:0] value);
		item_t it;
		it.op         = op;
		it.push_value = value;
		return it;
	endfunction

	// Hold start high until the block takes the command, then predict it
	task automatic send_cmd(item_t it, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		apply_stack_op(it);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (results_due.size() != 0);
	endtask

	always @(posedge clk) begin
		if (strobe) begin
			if (results_due.size() == 0) begin
				$error("result with nothing outstanding: read_value %0h status %0d last %0d",
					result.read_value, result.status, result.last);
				fail_count++;
			end else begin
				want_res = results_due.pop_front();
				if (result.read_value !== want_res.read_value) begin
					$error("read_value: expected %0h, got %0h",
						want_res.read_value, result.read_value);
					fail_count++;
				end
				if (result.status !== want_res.status) begin
					$error("status: expected %0d, got %0d", want_res.status, result.status);
					fail_count++;
				end
				if (result.last !== want_res.last) begin
					$error("last: expected %0d, got %0d", want_res.last, result.last);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int       k;
		int       sent;
		int       mode;
		int       len;
		int       r;
		logic [2:0] op;
		stim_row_t row;

		dir_rows = '{
			'{'{OP_POP_X,    32'h0},        1'b1, '{32'h0, ST_UNDER, 1'b1}},
			'{'{OP_POP_Y,    32'h0},        1'b1, '{32'h0, ST_UNDER, 1'b1}},
			'{'{OP_SHOW_X,   32'hffff_ffff}, 1'b1, '{32'h0, ST_UNDER, 1'b1}},
			'{'{OP_SHOW_Y,   32'h0},        1'b1, '{32'h0, ST_UNDER, 1'b1}},
			'{'{OP_PUSH_X,   32'h7fff_ffff}, 1'b1, '{32'h0, ST_OK, 1'b1}},
			'{'{OP_PUSH_X,   32'h8000_0000}, 1'b1, '{32'h0, ST_OK, 1'b1}},
			'{'{OP_PUSH_Y,   32'h0},        1'b1, '{32'h0, ST_OK, 1'b1}},
			'{'{OP_PUSH_Y,   32'hffff_ffff}, 1'b1, '{32'h0, ST_OK, 1'b1}},
			'{'{OP_PUSH_Y,   32'h1234_5678}, 1'b0, '{32'h0, ST_OK, 1'b0}},
			'{'{OP_SHOW_X,   32'h0},        1'b0, '{32'h0, ST_OK, 1'b0}},
			'{'{OP_SHOW_Y,   32'hffff_ffff}, 1'b0, '{32'h0, ST_OK, 1'b0}},
			'{'{OP_UNUSED_6, 32'hffff_ffff}, 1'b0, '{32'h0, ST_OK, 1'b0}},
			'{'{OP_UNUSED_7, 32'h5555_aaaa}, 1'b0, '{32'h0, ST_OK, 1'b0}},
			'{'{OP_POP_X,    32'h0},        1'b1, '{32'h8000_0000, ST_OK, 1'b1}},
			'{'{OP_POP_Y,    32'h0},        1'b0, '{32'h0, ST_OK, 1'b0}},
			'{'{OP_POP_Y,    32'h0},        1'b1, '{32'hffff_ffff, ST_OK, 1'b1}},
			'{'{OP_POP_X,    32'hffff_ffff}, 1'b1, '{32'h7fff_ffff, ST_OK, 1'b1}},
			'{'{OP_POP_X,    32'h0},        1'b1, '{32'h0, ST_UNDER, 1'b1}},
			'{'{OP_POP_Y,    32'h0},        1'b1, '{32'h0, ST_OK, 1'b1}},
			'{'{OP_SHOW_Y,   32'h0},        1'b1, '{32'h0, ST_UNDER, 1'b1}},
			'{'{OP_PUSH_X,   32'ha5a5_a5a5}, 1'b0, '{32'h0, ST_OK, 1'b0}},
			'{'{OP_SHOW_X,   32'hffff_ffff}, 1'b0, '{32'h0, ST_OK, 1'b0}}
		};

		x_cnt  = 0;
		y_cnt  = 0;
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_style = 1;
		for (k = 0; k < N_DIRECTED; k++) begin
			row = dir_rows[k];
			send_cmd(row.it, draw_gap());
			// Swap in the hand-written expectation where the row carries one
			if (row.check)
				results_due[results_due.size() - 1] = row.want;
		end

		// Fill X to the top, hit overflow from both sides, show a full stack
		idle_style = 0;
		while (x_cnt + y_cnt < DEPTH)
			send_cmd(mk_item(OP_PUSH_X, rand_word()), draw_gap());
		send_cmd(mk_item(OP_PUSH_X, rand_word()), 0);
		send_cmd(mk_item(OP_PUSH_Y, rand_word()), 0);
		send_cmd(mk_item(OP_SHOW_X, '0), 0);
		for (k = 0; k < 4; k++)
			send_cmd(mk_item(OP_POP_X, '0), 0);
		for (k = 0; k < 4; k++)
			send_cmd(mk_item(OP_PUSH_Y, rand_word()), 0);
		send_cmd(mk_item(OP_PUSH_Y, rand_word()), 0);
		send_cmd(mk_item(OP_SHOW_Y, '0), 0);
		send_cmd(mk_item(OP_SHOW_X, '0), 0);
		drain_results();

		sent = 0;
		while (sent < RANDOM_OPS) begin
			mode       = $urandom_range(0, 2);
			idle_style = $urandom_range(0, 2);
			len        = $urandom_range(8, 40);
			for (k = 0; k < len && sent < RANDOM_OPS; k++) begin
				r = $urandom_range(0, 99);
				case (mode)
					0:       op = r < 65 ? OP_PUSH_X : r < 80 ? OP_POP_X : r < 96 ? OP_SHOW_X
						: OP_UNUSED_6;
					1:       op = r < 20 ? OP_PUSH_X : r < 75 ? OP_POP_X : r < 96 ? OP_SHOW_X
						: OP_UNUSED_6;
					default: op = r < 40 ? OP_PUSH_X : r < 70 ? OP_POP_X : r < 96 ? OP_SHOW_X
						: OP_UNUSED_6;
				endcase
				// Pick the stack (or the other unused code) with the low bit
				op[0] = 1'($urandom_range(0, 1));
				send_cmd(mk_item(op, rand_word()), draw_gap());
				if (op <= OP_SHOW_Y)
					sent++;
			end
			if ($urandom_range(0, 3) == 0)
				drain_results();
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && results_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
